[src/fpa_pkg.sv]
// Shared constants, types and helpers for the Q24.8 fixed-point ALU.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int DIV_W     = DATA_W + FRAC_BITS;  // dividend width, one cell per bit
  localparam int MAG_W     = 64;

  localparam logic [3:0] ACT_ADD  = 4'd0;
  localparam logic [3:0] ACT_SUB  = 4'd1;
  localparam logic [3:0] ACT_MUL  = 4'd2;
  localparam logic [3:0] ACT_DIV  = 4'd3;
  localparam logic [3:0] ACT_GT   = 4'd4;
  localparam logic [3:0] ACT_LT   = 4'd5;
  localparam logic [3:0] ACT_GE   = 4'd6;
  localparam logic [3:0] ACT_LE   = 4'd7;
  localparam logic [3:0] ACT_EQ   = 4'd8;
  localparam logic [3:0] ACT_NE   = 4'd9;
  localparam logic [3:0] ACT_INC  = 4'd10;
  localparam logic [3:0] ACT_DEC  = 4'd11;
  localparam logic [3:0] ACT_MIN  = 4'd12;
  localparam logic [3:0] ACT_MAX  = 4'd13;
  localparam logic [3:0] ACT_FINT = 4'd14;
  localparam logic [3:0] ACT_TINT = 4'd15;

  typedef struct packed {
    logic              valid;
    logic              is_div;
    logic              neg;
    logic              dz;
    logic [DATA_W-1:0] mb;
    logic [DATA_W-1:0] rem;
    logic [DIV_W-1:0]  nq;    // dividend bits in, quotient bits out
    logic [DATA_W-1:0] r;
    logic              cmp;
    logic              ovf;
  } cell_t;

  // Apply sign to a magnitude and saturate; returns {overflow, value}.
  function automatic logic [DATA_W:0] sat_mag(input logic [MAG_W-1:0] m, input logic neg);
    logic [DATA_W-1:0] lo;
    lo = m[DATA_W-1:0];
    if (neg) begin
      if (m > (MAG_W'(1) << (DATA_W - 1))) sat_mag = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
      else sat_mag = {1'b0, DATA_W'(-lo)};
    end else begin
      if (m > ((MAG_W'(1) << (DATA_W - 1)) - MAG_W'(1)))
        sat_mag = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
      else sat_mag = {1'b0, lo};
    end
  endfunction

  // Saturate a 33-bit signed sum; returns {overflow, value}.
  function automatic logic [DATA_W:0] sat_sum(input logic [DATA_W:0] s);
    if (s[DATA_W] != s[DATA_W-1])
      sat_sum = {1'b1, s[DATA_W], {(DATA_W-1){~s[DATA_W]}}};
    else sat_sum = {1'b0, s[DATA_W-1:0]};
  endfunction

endpackage

[src/fpa_front.sv]
// Front end: operand decode, simple ops, multiplier and its rounding (two stages).
module fpa_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [3:0]                  in_action,
  input  logic signed [31:0]          in_operand_a,
  input  logic signed [31:0]          in_operand_b,
  output fpa_pkg::cell_t              cell_o
);

  localparam int DW = fpa_pkg::DATA_W;

  logic              v_r;
  logic [3:0]        act_r;
  logic              neg_r;
  logic [DW-1:0]     ma_r, mb_r;
  logic [63:0]       p_r;
  logic [DW-1:0]     r_r;
  logic              cmp_r, ovf_r, dz_r;

  logic [DW-1:0]     ma_nxt, mb_nxt, r_nxt;
  logic              cmp_nxt, ovf_nxt;
  logic [DW:0]       sat;
  logic [DW+fpa_pkg::FRAC_BITS-1:0] fint;
  logic [DW-1:0]     tint;

  always_comb begin
    ma_nxt  = in_operand_a[DW-1] ? DW'(-in_operand_a) : in_operand_a;
    mb_nxt  = in_operand_b[DW-1] ? DW'(-in_operand_b) : in_operand_b;
    r_nxt   = '0;
    cmp_nxt = 1'b0;
    ovf_nxt = 1'b0;
    sat     = '0;
    fint    = {{fpa_pkg::FRAC_BITS{in_operand_a[DW-1]}}, in_operand_a} << fpa_pkg::FRAC_BITS;
    tint    = ma_nxt >> fpa_pkg::FRAC_BITS;
    case (in_action)
      fpa_pkg::ACT_ADD: sat = fpa_pkg::sat_sum({in_operand_a[DW-1], in_operand_a}
                                               + {in_operand_b[DW-1], in_operand_b});
      fpa_pkg::ACT_SUB: sat = fpa_pkg::sat_sum({in_operand_a[DW-1], in_operand_a}
                                               - {in_operand_b[DW-1], in_operand_b});
      fpa_pkg::ACT_INC: sat = fpa_pkg::sat_sum({in_operand_a[DW-1], in_operand_a} + (DW+1)'(1));
      fpa_pkg::ACT_DEC: sat = fpa_pkg::sat_sum({in_operand_a[DW-1], in_operand_a} - (DW+1)'(1));
      fpa_pkg::ACT_GT:  cmp_nxt = in_operand_a >  in_operand_b;
      fpa_pkg::ACT_LT:  cmp_nxt = in_operand_a <  in_operand_b;
      fpa_pkg::ACT_GE:  cmp_nxt = in_operand_a >= in_operand_b;
      fpa_pkg::ACT_LE:  cmp_nxt = in_operand_a <= in_operand_b;
      fpa_pkg::ACT_EQ:  cmp_nxt = in_operand_a == in_operand_b;
      fpa_pkg::ACT_NE:  cmp_nxt = in_operand_a != in_operand_b;
      fpa_pkg::ACT_MIN: sat = {1'b0, (in_operand_a < in_operand_b) ? in_operand_a : in_operand_b};
      fpa_pkg::ACT_MAX: sat = {1'b0, (in_operand_a > in_operand_b) ? in_operand_a : in_operand_b};
      fpa_pkg::ACT_FINT: begin
        // fits when the bits above the sign all match it
        if (fint[DW+fpa_pkg::FRAC_BITS-1:DW-1] == '0 || fint[DW+fpa_pkg::FRAC_BITS-1:DW-1] == '1)
          sat = {1'b0, fint[DW-1:0]};
        else sat = {1'b1, in_operand_a[DW-1], {(DW-1){~in_operand_a[DW-1]}}};
      end
      fpa_pkg::ACT_TINT: sat = {1'b0, in_operand_a[DW-1] ? DW'(-tint) : tint};
      default: sat = '0;
    endcase
    ovf_nxt = sat[DW];
    r_nxt   = sat[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= in_valid;
    if (en) begin
      act_r <= in_action;
      neg_r <= in_operand_a[DW-1] ^ in_operand_b[DW-1];
      ma_r  <= ma_nxt;
      mb_r  <= mb_nxt;
      p_r   <= 64'(ma_nxt) * 64'(mb_nxt);
      r_r   <= r_nxt;
      cmp_r <= cmp_nxt;
      ovf_r <= ovf_nxt;
      dz_r  <= (in_action == fpa_pkg::ACT_DIV) && (in_operand_b == '0);
    end
  end

  // second stage: round the product half away from zero, set up the divider
  fpa_pkg::cell_t c_nxt, c_r;
  logic [63:0]    pq;
  logic [DW:0]    msat;

  always_comb begin
    pq   = (p_r + (64'(1) << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
    msat = fpa_pkg::sat_mag(pq, neg_r);
    c_nxt        = '0;
    c_nxt.valid  = v_r;
    c_nxt.is_div = (act_r == fpa_pkg::ACT_DIV);
    c_nxt.neg    = neg_r;
    c_nxt.dz     = dz_r;
    c_nxt.mb     = mb_r;
    c_nxt.rem    = '0;
    c_nxt.nq     = {ma_r, {fpa_pkg::FRAC_BITS{1'b0}}};
    c_nxt.r      = (act_r == fpa_pkg::ACT_MUL) ? msat[DW-1:0] : r_r;
    c_nxt.cmp    = cmp_r;
    c_nxt.ovf    = (act_r == fpa_pkg::ACT_MUL) ? msat[DW] : ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_r.valid <= 1'b0;
    else if (en) c_r <= c_nxt;
  end

  assign cell_o = c_r;

endmodule

[src/fpa_div_cell.sv]
// One restoring-division cell: retires one quotient bit and passes the item on.
module fpa_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  fpa_pkg::cell_t cell_i,
  output fpa_pkg::cell_t cell_o
);

  localparam int DW = fpa_pkg::DATA_W;

  fpa_pkg::cell_t c_r, c_nxt;
  logic [DW:0]    t;
  logic           ge;

  always_comb begin
    t     = {cell_i.rem, cell_i.nq[fpa_pkg::DIV_W-1]};
    ge    = t >= {1'b0, cell_i.mb};
    c_nxt = cell_i;
    c_nxt.rem = ge ? DW'(t - {1'b0, cell_i.mb}) : t[DW-1:0];
    c_nxt.nq  = {cell_i.nq[fpa_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) c_r.valid <= 1'b0;
    else if (en) c_r <= c_nxt;
  end

  assign cell_o = c_r;

endmodule

[src/fpa_back.sv]
// Back end: quotient rounding, saturation and the output register.
module fpa_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  fpa_pkg::cell_t       cell_i,
  output logic                 out_valid,
  output logic signed [31:0]   out_result_value,
  output logic                 out_compare_true,
  output logic                 out_overflow,
  output logic                 out_divide_by_zero
);

  localparam int DW = fpa_pkg::DATA_W;

  logic              v_r, cmp_r, ovf_r, dz_r;
  logic [DW-1:0]     r_r;
  logic [DW-1:0]     r_nxt;
  logic              ovf_nxt;
  logic              rnd;
  logic [DW:0]       dsat;

  always_comb begin
    // round the quotient magnitude half up (half away from zero): 2*rem >= divisor
    rnd     = {cell_i.rem, 1'b0} >= {1'b0, cell_i.mb};
    dsat    = fpa_pkg::sat_mag(fpa_pkg::MAG_W'(cell_i.nq) + fpa_pkg::MAG_W'(rnd), cell_i.neg);
    r_nxt   = cell_i.r;
    ovf_nxt = cell_i.ovf;
    if (cell_i.is_div) begin
      r_nxt   = cell_i.dz ? '0 : dsat[DW-1:0];
      ovf_nxt = cell_i.dz ? 1'b0 : dsat[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= cell_i.valid;
    if (en) begin
      r_r   <= r_nxt;
      ovf_r <= ovf_nxt;
      cmp_r <= cell_i.cmp;
      dz_r  <= cell_i.dz;
    end
  end

  assign out_valid          = v_r;
  assign out_result_value   = r_r;
  assign out_compare_true   = cmp_r;
  assign out_overflow       = ovf_r;
  assign out_divide_by_zero = dz_r;

endmodule

[src/q24_8_fixed_point_alu.sv]
// Q24.8 fixed-point ALU, top level.
// Takes one item per cycle, unless stalled, and returns one result per item, in order.
// Every item travels the same pipeline: two front stages (decode, simple ops, 32x32
// multiply and rounding), a chain of 40 division cells (one quotient bit per cell,
// DATA_W+FRAC_BITS cells), and an output register. The whole pipeline holds only
// while a result waits at the output and out_ready is low.
module q24_8_fixed_point_alu (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_action,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic               out_compare_true,
  output logic               out_overflow,
  output logic               out_divide_by_zero
);

  localparam int NCELL = fpa_pkg::DIV_W;

  logic           en;
  fpa_pkg::cell_t chain [0:NCELL];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  fpa_front u_front (
    .clk, .rst_n, .en, .in_valid, .in_action, .in_operand_a, .in_operand_b,
    .cell_o(chain[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk, .rst_n, .en, .cell_i(chain[i]), .cell_o(chain[i+1])
    );
  end

  fpa_back u_back (
    .clk, .rst_n, .en, .cell_i(chain[NCELL]),
    .out_valid, .out_result_value, .out_compare_true, .out_overflow, .out_divide_by_zero
  );

`ifndef SYNTHESIS
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_result_value == '0 && !out_overflow)
    else $error("divide by zero result not clean");
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_compare_true |-> out_result_value == '0 && !out_overflow)
    else $error("compare result carries a value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value))
    else $error("stalled result changed");
`endif

endmodule
